[rtl/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SRSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SRSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/srsi_pkg.sv]
// types, constants and codes of the moving average and rsi signal block
package srsi_pkg;

    localparam int PRICE_BITS     = 32;
    localparam int AVG_W          = 32;
    localparam int WIN_W          = 9;
    localparam int LEVEL_W        = 7;
    localparam int RSI_W          = 15;
    localparam int RSI_FRAC       = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MAX_WINDOW_DEF = 256;
    localparam int DIV_W_DEF      = PRICE_BITS + $clog2(MAX_WINDOW_DEF) + 1 + LEVEL_W + 1
                                    + RSI_FRAC;

    localparam logic [WIN_W-1:0]   WINDOW_RESET     = 9'd14;
    localparam logic [LEVEL_W-1:0] OVERSOLD_RESET   = 7'd30;
    localparam logic [LEVEL_W-1:0] OVERBOUGHT_RESET = 7'd70;
    localparam logic [LEVEL_W-1:0] PCT_FULL         = 7'd100;
    localparam logic [RSI_W-1:0]   RSI_FULL         = 15'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW     = 2'd0,
        CFG_OVERSOLD   = 2'd1,
        CFG_OVERBOUGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_BUY  = 2'd1,
        DEC_SELL = 2'd2,
        DEC_HOLD = 2'd3
    } decision_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_EVAL   = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_EVAL,
        BK_DIV_AVG,
        BK_DIV_RSI,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic                  req_type;
        logic [PRICE_BITS-1:0] price;
        logic                  missing;
    } req_item_t;

    typedef struct packed {
        decision_t          decision;
        logic [AVG_W-1:0]   average;
        logic [RSI_W-1:0]   strength_index;
    } res_item_t;

    typedef struct packed {
        logic                  is_eval;
        logic [PRICE_BITS-1:0] price;
    } cmd_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window_length;
        logic [LEVEL_W-1:0] oversold_level;
        logic [LEVEL_W-1:0] overbought_level;
    } cfg_t;

    typedef struct packed {
        logic history_empty;
        logic window_full;
    } back_status_t;

endpackage

[rtl/srsi_chan_if.sv]
// valid/ready channel carrying one request or result
interface srsi_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[rtl/sma_rsi_signal.sv]
// moving average and rsi trading signal, top level
// history sample: in the back end, a ring read, then a sum update
// evaluate: the one-bit-per-cycle divider (DIV_W = 57 at default) runs for the average and then
// the rsi, with the rsi run skipped when the loss sum is zero; not enough data skips the divider
// reset: control and history clear at once, config returns to 14/30/70, ring holds no reset
`include "assert_macros.svh"

module sma_rsi_signal #(
    parameter int MAX_WINDOW = srsi_pkg::MAX_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    srsi_chan_if.sink                       req_chan,
    srsi_chan_if.source                     res_chan,
    input  logic                            cfg_we,
    input  logic [srsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srsi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srsi_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    logic         clear;
    logic         cmd_valid;
    logic         cmd_pop;
    cmd_t         cmd;
    back_status_t status;

    assign clear = cfg_we && (cfg_index == CFG_WINDOW);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW:     cfg_next.window_length    = cfg_data;
                CFG_OVERSOLD:   cfg_next.oversold_level   = cfg_data[LEVEL_W-1:0];
                CFG_OVERBOUGHT: cfg_next.overbought_level = cfg_data[LEVEL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length    <= WINDOW_RESET;
            cfg_reg.oversold_level   <= OVERSOLD_RESET;
            cfg_reg.overbought_level <= OVERBOUGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_chan  (req_chan),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    srsi_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clear     (clear),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_chan  (res_chan),
        .status    (status)
    );

    `SRSI_ASSERT_NOW(a_none_is_zero, res_chan.valid && res_chan.data.decision == DEC_NONE, res_chan.data.average == '0 && res_chan.data.strength_index == '0)
    `SRSI_ASSERT_NOW(a_rsi_range, res_chan.valid, res_chan.data.strength_index <= RSI_FULL)
    `SRSI_ASSERT_NEXT(a_window_clears, cfg_we && cfg_index == CFG_WINDOW, status.history_empty)
    `SRSI_ASSERT_NOW(a_empty_not_full, status.history_empty, !status.window_full)

endmodule

[rtl/srsi_front.sv]
// front end: accepts requests, drops missing samples, queues commands
module srsi_front (
    input  logic           clk,
    input  logic           rst_n,
    srsi_chan_if.sink      req_chan,
    input  logic           cmd_pop,
    output logic           cmd_valid,
    output srsi_pkg::cmd_t cmd
);
    import srsi_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    cmd_t          queue_mem [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC-1:0] count_reg, count_next;
    logic          push;
    cmd_t          entry;

    assign req_chan.ready = (count_reg != QC'(QUEUE_DEPTH));
    assign push           = req_chan.valid && req_chan.ready
                            && ((req_chan.data.req_type == REQ_EVAL) || !req_chan.data.missing);
    assign entry.is_eval  = (req_chan.data.req_type == REQ_EVAL);
    assign entry.price    = req_chan.data.price;

    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

[rtl/srsi_div.sv]
// restoring divider, one quotient bit per cycle
module srsi_div #(
    parameter int W = srsi_pkg::DIV_W_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    import srsi_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             take;

    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign take     = !diff[W];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], take};
        end
    end

endmodule

[rtl/srsi_back.sv]
// back end: price ring, running sums, evaluation and result register
module srsi_back #(
    parameter int MAX_WINDOW = srsi_pkg::MAX_WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srsi_pkg::cfg_t         cfg,
    input  logic                   clear,
    input  logic                   cmd_valid,
    input  srsi_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    srsi_chan_if.source            res_chan,
    output srsi_pkg::back_status_t status
);
    import srsi_pkg::*;

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int ACC_W  = PRICE_BITS + AW;
    localparam int SUM_W  = ACC_W + 1;
    localparam int PROD_W = SUM_W + LEVEL_W + 1;
    localparam int PN_W   = PRICE_BITS + CW;
    localparam int DIV_W  = PROD_W + RSI_FRAC;

    back_state_t state_reg, state_next;

    logic [CW-1:0]         n;
    logic [CW-1:0]         vc_reg, vc_next;
    logic [AW-1:0]         ws_reg, ws_next, ws_nx;
    logic [AW:0]           ws_plus;
    logic [ACC_W-1:0]      total_reg, total_next;
    logic [ACC_W-1:0]      gain_reg, gain_next;
    logic [ACC_W-1:0]      loss_reg, loss_next;
    logic [PRICE_BITS-1:0] newest_reg;
    logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [PRICE_BITS-1:0] old_reg, nxt_reg;
    cmd_t                  cmd_reg;

    logic                  full, multi, do_add, do_drop, add_up, drop_up;
    logic [PRICE_BITS-1:0] add_mag, drop_mag;
    logic [ACC_W-1:0]      gain_add, gain_sub, loss_add, loss_sub;

    logic [SUM_W-1:0]      sum, sum_reg;
    logic [PROD_W-1:0]     g100, g100_reg;
    logic [PROD_W-1:0]     os_prod, os_prod_reg;
    logic [PROD_W-1:0]     ob_prod, ob_prod_reg;
    logic [PN_W-1:0]       pn, pn_reg;
    logic                  loss_zero_reg;
    logic                  low, high, above, below;
    decision_t             dec;
    decision_t             dec_reg;
    logic [AVG_W-1:0]      avg_reg;
    logic [RSI_W-1:0]      rsi_reg;

    logic                  div_start, div_done;
    logic [DIV_W-1:0]      div_dividend, div_divisor, div_quot;

    logic                  res_valid_reg, res_valid_next;
    logic                  res_load;
    res_item_t             res_data_reg;

    // window clamp
    always_comb
    begin
        if (cfg.window_length == '0)
        begin
            n = CW'(1);
        end
        else if (32'(cfg.window_length) > MAX_WINDOW)
        begin
            n = CW'(MAX_WINDOW);
        end
        else
        begin
            n = CW'(cfg.window_length);
        end
    end

    assign ws_plus = (AW + 1)'(ws_reg) + (AW + 1)'(1);
    assign ws_nx   = (ws_plus == (AW + 1)'(n)) ? '0 : ws_plus[AW-1:0];
    assign full    = (vc_reg >= n);
    assign multi   = (n > CW'(1));

    // sample update
    assign add_up   = cmd_reg.price > newest_reg;
    assign add_mag  = add_up ? cmd_reg.price - newest_reg : newest_reg - cmd_reg.price;
    assign drop_up  = nxt_reg > old_reg;
    assign drop_mag = drop_up ? nxt_reg - old_reg : old_reg - nxt_reg;
    assign do_add   = full ? multi : (vc_reg != '0);
    assign do_drop  = full && multi;
    assign gain_add = (do_add && add_up) ? ACC_W'(add_mag) : '0;
    assign loss_add = (do_add && !add_up) ? ACC_W'(add_mag) : '0;
    assign gain_sub = (do_drop && drop_up) ? ACC_W'(drop_mag) : '0;
    assign loss_sub = (do_drop && !drop_up) ? ACC_W'(drop_mag) : '0;

    assign gain_next  = gain_reg + gain_add - gain_sub;
    assign loss_next  = loss_reg + loss_add - loss_sub;
    assign total_next = total_reg + ACC_W'(cmd_reg.price) - (full ? ACC_W'(old_reg) : '0);
    assign vc_next    = full ? vc_reg : vc_reg + 1'b1;
    assign ws_next    = ws_nx;

    // evaluate operands
    assign sum     = SUM_W'(gain_reg) + SUM_W'(loss_reg);
    assign g100    = (PROD_W'(gain_reg) << 6) + (PROD_W'(gain_reg) << 5)
                     + (PROD_W'(gain_reg) << 2);
    assign os_prod = PROD_W'(sum) * PROD_W'(cfg.oversold_level);
    assign ob_prod = PROD_W'(sum) * PROD_W'(cfg.overbought_level);
    assign pn      = PN_W'(cmd_reg.price) * PN_W'(n);

    assign low   = loss_zero_reg ? (PCT_FULL < cfg.oversold_level) : (g100_reg < os_prod_reg);
    assign high  = loss_zero_reg ? (PCT_FULL > cfg.overbought_level) : (g100_reg > ob_prod_reg);
    assign above = pn_reg > PN_W'(total_reg);
    assign below = pn_reg < PN_W'(total_reg);

    always_comb
    begin
        if (low && above)
        begin
            dec = DEC_BUY;
        end
        else if (high && below)
        begin
            dec = DEC_SELL;
        end
        else
        begin
            dec = DEC_HOLD;
        end
    end

    srsi_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        res_load     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = cmd.is_eval ? BK_EVAL : BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                state_next = BK_IDLE;
            end
            BK_EVAL:
            begin
                if (!full)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(total_reg);
                    div_divisor  = DIV_W'(n);
                    state_next   = BK_DIV_AVG;
                end
            end
            BK_DIV_AVG:
            begin
                if (div_done)
                begin
                    if (loss_zero_reg)
                    begin
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = {g100_reg, {RSI_FRAC{1'b0}}};
                        div_divisor  = DIV_W'(sum_reg);
                        state_next   = BK_DIV_RSI;
                    end
                end
            end
            BK_DIV_RSI:
            begin
                if (div_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!res_valid_reg || res_chan.ready)
                begin
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_chan.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg     <= '0;
            ws_reg     <= '0;
            total_reg  <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            newest_reg <= '0;
        end
        else if (clear)
        begin
            vc_reg     <= '0;
            ws_reg     <= '0;
            total_reg  <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            newest_reg <= '0;
        end
        else if (state_reg == BK_UPDATE)
        begin
            vc_reg     <= vc_next;
            ws_reg     <= ws_next;
            total_reg  <= total_next;
            gain_reg   <= gain_next;
            loss_reg   <= loss_next;
            newest_reg <= cmd_reg.price;
        end
    end

    // ring, read ports registered
    always_ff @(posedge clk)
    begin
        old_reg <= ring_mem[ws_reg];
        nxt_reg <= ring_mem[ws_nx];
        if (state_reg == BK_UPDATE)
        begin
            ring_mem[ws_reg] <= cmd_reg.price;
        end
    end

    // evaluation datapath
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == BK_EVAL)
        begin
            sum_reg       <= sum;
            g100_reg      <= g100;
            os_prod_reg   <= os_prod;
            ob_prod_reg   <= ob_prod;
            pn_reg        <= pn;
            loss_zero_reg <= (loss_reg == '0);
            dec_reg       <= DEC_NONE;
            avg_reg       <= '0;
            rsi_reg       <= '0;
        end
        if (state_reg == BK_DIV_AVG && div_done)
        begin
            avg_reg <= div_quot[AVG_W-1:0];
            dec_reg <= dec;
            if (loss_zero_reg)
            begin
                rsi_reg <= RSI_FULL;
            end
        end
        if (state_reg == BK_DIV_RSI && div_done)
        begin
            rsi_reg <= div_quot[RSI_W-1:0];
        end
        if (res_load)
        begin
            res_data_reg.decision       <= dec_reg;
            res_data_reg.average        <= avg_reg;
            res_data_reg.strength_index <= rsi_reg;
        end
    end

    assign res_chan.valid = res_valid_reg;
    assign res_chan.data  = res_data_reg;

    assign status.history_empty = (vc_reg == '0);
    assign status.window_full   = full;

endmodule
